@@ rtl/core/bia_pkg.sv @@
package bia_pkg;

   localparam int NUM_BUFS   = 64;
   localparam int OWNER_BITS = 8;
   localparam int ID_W       = $clog2(NUM_BUFS);
   localparam int CNT_W      = ID_W + 1;
   localparam int LAST_ID    = NUM_BUFS - 1;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_FREE     = 2'd1,
      OP_FREE_ALL = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [OWNER_BITS-1:0] owner;
      logic [ID_W-1:0]       buffer_id;
   } req_type;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] granted_id;
      logic [ID_W-1:0] freed_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic alloc;
      logic free_one;
      logic ignore;
      logic scan_issue;
      logic scan_check;
      logic scan_finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } sts_type;

endpackage

@@ rtl/core/bia_ctrl.sv @@
module bia_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       operation,
   input  bia_pkg::sts_type sts,
   output bia_pkg::cmd_type cmd,
   output logic             busy
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_ALLOC    = 6'b000010,
      S_FREE     = 6'b000100,
      S_IGNORE   = 6'b001000,
      S_SCAN     = 6'b010000,
      S_SCAN_END = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (operation)
                  bia_pkg::OP_ALLOC:    state_in = S_ALLOC;
                  bia_pkg::OP_FREE:     state_in = S_FREE;
                  bia_pkg::OP_FREE_ALL: state_in = S_SCAN;
                  default:              state_in = S_IGNORE;
               endcase
            end
         end
         S_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = S_IDLE;
         end
         S_FREE: begin
            cmd.free_one = 1'b1;
            state_in     = S_IDLE;
         end
         S_IGNORE: begin
            cmd.ignore = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCAN: begin
            // Issue the next owner read while checking the one read last cycle.
            cmd.scan_issue = 1'b1;
            cmd.scan_check = 1'b1;
            if (sts.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            cmd.scan_check  = 1'b1;
            cmd.scan_finish = 1'b1;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/core/bia_datapath.sv @@
module bia_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bia_pkg::req_type req_data,
   input  bia_pkg::cmd_type cmd,
   output bia_pkg::sts_type sts,
   output logic             rsp_valid,
   output bia_pkg::rsp_type rsp_data
);

   localparam logic [bia_pkg::ID_W-1:0]  LAST    = bia_pkg::ID_W'(bia_pkg::LAST_ID);
   localparam logic [bia_pkg::CNT_W-1:0] FULL    = bia_pkg::CNT_W'(bia_pkg::LAST_ID);
   localparam logic [bia_pkg::ID_W-1:0]  FIRST   = bia_pkg::ID_W'(1);

   logic [bia_pkg::ID_W-1:0]       fifo_mem [bia_pkg::NUM_BUFS];
   logic [bia_pkg::OWNER_BITS-1:0] owner_mem [bia_pkg::NUM_BUFS];

   bia_pkg::req_type               req_ff;
   logic [bia_pkg::ID_W-1:0]       head_ff;
   logic [bia_pkg::ID_W-1:0]       head_in;
   logic [bia_pkg::ID_W-1:0]       tail_ff;
   logic [bia_pkg::ID_W-1:0]       tail_in;
   logic [bia_pkg::CNT_W-1:0]      count_ff;
   logic [bia_pkg::CNT_W-1:0]      count_in;
   logic                           first_lap_ff;
   logic                           first_lap_in;
   logic [bia_pkg::NUM_BUFS-1:0]   alloc_bits_ff;
   logic [bia_pkg::NUM_BUFS-1:0]   alloc_bits_in;
   logic [bia_pkg::ID_W-1:0]       fifo_rd_ff;
   logic [bia_pkg::OWNER_BITS-1:0] owner_rd_ff;
   logic [bia_pkg::ID_W-1:0]       scan_ptr_ff;
   logic [bia_pkg::ID_W-1:0]       cmp_id_ff;
   logic                           cmp_valid_ff;
   logic [bia_pkg::ID_W-1:0]       freed_ff;
   logic [bia_pkg::ID_W-1:0]       freed_in;
   bia_pkg::rsp_type               rsp_ff;
   bia_pkg::rsp_type               rsp_in;
   logic                           rsp_valid_ff;

   logic                           list_empty;
   logic [bia_pkg::ID_W-1:0]       alloc_id;
   logic                           pop;
   logic [bia_pkg::ID_W-1:0]       rel_id;
   logic                           rel_try;
   logic                           rel_ok;
   logic                           scan_hit;

   assign list_empty = (count_ff == '0);
   assign pop        = cmd.alloc && !list_empty;

   // Until the head has wrapped once, the slot under it (but for the last) was never written, so the id is head + 1.
   assign alloc_id = (first_lap_ff && head_ff != LAST) ? head_ff + 1'b1 : fifo_rd_ff;

   assign scan_hit = cmd.scan_check && cmp_valid_ff && (owner_rd_ff == req_ff.owner);
   assign rel_id   = cmd.free_one ? req_ff.buffer_id : cmp_id_ff;
   assign rel_try  = cmd.free_one || scan_hit;
   assign rel_ok   = rel_try && (rel_id != '0) && alloc_bits_ff[rel_id] && (count_ff < FULL);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      first_lap_in  = first_lap_ff;
      alloc_bits_in = alloc_bits_ff;
      if (pop) begin
         head_in                 = (head_ff == LAST) ? '0 : head_ff + 1'b1;
         count_in                = count_ff - 1'b1;
         alloc_bits_in[alloc_id] = 1'b1;
         if (head_ff == LAST) begin
            first_lap_in = 1'b0;
         end
      end else if (rel_ok) begin
         tail_in               = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
         count_in              = count_ff + 1'b1;
         alloc_bits_in[rel_id] = 1'b0;
      end
   end

   always_comb begin
      freed_in = freed_ff;
      if (cmd.load) begin
         freed_in = '0;
      end else if (cmd.scan_check && rel_ok) begin
         freed_in = freed_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in = '{status: bia_pkg::ST_IGNORED, granted_id: '0, freed_count: '0};
      if (cmd.alloc) begin
         if (list_empty) begin
            rsp_in.status = bia_pkg::ST_EMPTY;
         end else begin
            rsp_in.status     = bia_pkg::ST_DONE;
            rsp_in.granted_id = alloc_id;
         end
      end else if (cmd.free_one) begin
         if (rel_ok) begin
            rsp_in.status      = bia_pkg::ST_DONE;
            rsp_in.freed_count = FIRST;
         end
      end else if (cmd.scan_finish) begin
         rsp_in.status      = bia_pkg::ST_DONE;
         rsp_in.freed_count = freed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= LAST;
         count_ff      <= FULL;
         first_lap_ff  <= 1'b1;
         alloc_bits_ff <= bia_pkg::NUM_BUFS'(1);
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         first_lap_ff  <= first_lap_in;
         alloc_bits_ff <= alloc_bits_in;
         cmp_valid_ff  <= cmd.scan_issue;
         rsp_valid_ff  <= cmd.alloc || cmd.free_one || cmd.ignore || cmd.scan_finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         scan_ptr_ff <= FIRST;
      end else if (cmd.scan_issue) begin
         scan_ptr_ff <= scan_ptr_ff + 1'b1;
      end
      cmp_id_ff <= scan_ptr_ff;
      freed_ff  <= freed_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (rel_ok) begin
         fifo_mem[tail_ff] <= rel_id;
      end
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         owner_mem[alloc_id] <= req_ff.owner;
      end
      owner_rd_ff <= owner_mem[scan_ptr_ff];
   end

   assign sts.scan_last = (scan_ptr_ff == LAST);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

@@ rtl/core/buffer_id_allocator_core.sv @@
// Allocate, free and unused commands enter their command state at the accepting edge and
// return to idle as rsp_valid rises; the word and the next start are taken at the same edge.
// Free-all walks ids 1 to 63 through the owner table read port, one id a cycle.
// Synchronous active-high reset restores the free list to ids 1 to 63 in order, clears
// every allocation but id 0, and needs no clearing pass. The receiver cannot stall.
module buffer_id_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bia_pkg::req_type req_data,
   output logic             rsp_valid,
   output bia_pkg::rsp_type rsp_data
);

   bia_pkg::cmd_type cmd;
   bia_pkg::sts_type sts;

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   bia_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/bia_checker.sv @@
module bia_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input bia_pkg::req_type req_data,
   input logic             rsp_valid,
   input bia_pkg::rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make the block busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == bia_pkg::ST_EMPTY |->
         rsp_data.granted_id == '0 && rsp_data.freed_count == '0)
      else $error("empty response carries an id or a count");

   a_grant_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted_id != '0 |->
         rsp_data.status == bia_pkg::ST_DONE && rsp_data.freed_count == '0)
      else $error("granted id with a bad status or count");

endmodule

bind buffer_id_allocator_core bia_checker u_bia_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

@@ verif/buffer_id_allocator_core_tb.sv @@
module buffer_id_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bia_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int          TARGET_ITEMS = 1850;

   typedef struct {
      req_type word;
      bit      hold_off;
   } queued_command;

   typedef struct {
      rsp_type     word;
      int unsigned stamp;
   } due_reply;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   buffer_id_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Shadow of the id pool.
   logic [ID_W-1:0]       free_ring [NUM_BUFS];
   logic [OWNER_BITS-1:0] owner_of [NUM_BUFS];
   bit                    held [NUM_BUFS];
   int                    ring_head;
   int                    ring_tail;
   int                    ids_free;

   queued_command command_queue[$];
   due_reply      replies_due[$];

   int unsigned cycle_count = 0;
   int unsigned n_queued    = 0;
   int unsigned n_accepted  = 0;
   int unsigned n_returned  = 0;
   int          burst_left  = 0;
   int          idle_left   = 0;
   bit          failed      = 1'b0;

   function automatic void reset_pool();
      for (int i = 0; i < NUM_BUFS; i++) begin
         free_ring[i] = (i < LAST_ID) ? ID_W'(i + 1) : '0;
         owner_of[i]  = '0;
         held[i]      = 1'b0;
      end
      held[0]   = 1'b1;
      ring_head = 0;
      ring_tail = LAST_ID;
      ids_free  = LAST_ID;
   endfunction

   function automatic bit give_back(int id);
      if (id == 0 || id >= NUM_BUFS || !held[id] || ids_free >= LAST_ID)
         return 1'b0;
      free_ring[ring_tail] = ID_W'(id);
      ring_tail            = (ring_tail == LAST_ID) ? 0 : ring_tail + 1;
      ids_free++;
      owner_of[id] = '0;
      held[id]     = 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type pool_reply(req_type cmd);
      rsp_type r;
      int      id;
      r.status      = ST_IGNORED;
      r.granted_id  = '0;
      r.freed_count = '0;
      case (cmd.operation)
         OP_ALLOC: begin
            if (ids_free == 0) begin
               r.status = ST_EMPTY;
            end else begin
               id        = int'(free_ring[ring_head]);
               ring_head = (ring_head == LAST_ID) ? 0 : ring_head + 1;
               ids_free--;
               owner_of[id] = cmd.owner;
               held[id]     = 1'b1;
               r.granted_id = ID_W'(id);
               r.status     = ST_DONE;
            end
         end
         OP_FREE: begin
            if (give_back(int'(cmd.buffer_id))) begin
               r.status      = ST_DONE;
               r.freed_count = ID_W'(1);
            end
         end
         OP_FREE_ALL: begin
            // Id 0 stays with owner 0 forever, so the walk starts at 1.
            for (int i = 1; i < NUM_BUFS; i++) begin
               if (held[i] && owner_of[i] == cmd.owner && give_back(i))
                  r.freed_count = r.freed_count + 1'b1;
            end
            r.status = ST_DONE;
         end
         default: ;
      endcase
      return r;
   endfunction

   int real_items = 0;

   task automatic push_command(logic [1:0] op, int own, int bid, bit hold);
      queued_command c;
      c.word.operation = op;
      c.word.owner     = OWNER_BITS'(own);
      c.word.buffer_id = ID_W'(bid);
      c.hold_off       = hold;
      command_queue.push_back(c);
      if (op != OP_UNUSED)
         real_items++;
   endtask

   // Mostly a handful of owners, so free-all finds something to release.
   function automatic int pick_owner();
      return ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 255));
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Driver: a word is taken at an edge where start is high and busy is low.
   always @(posedge clock) begin : drive
      bit accepted_now;
      int outstanding;
      accepted_now = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            due_reply d;
            d.word  = pool_reply(req_data);
            d.stamp = cycle_count;
            replies_due.push_back(d);
            void'(command_queue.pop_front());
            n_accepted   <= n_accepted + 1;
            accepted_now = 1'b1;
         end
         outstanding = int'(n_accepted) + int'(accepted_now) - int'(n_returned);
         if (start && !accepted_now) begin
            // Still waiting for the block to take the current word.
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (command_queue.size() == 0 ||
                      (command_queue[0].hold_off && outstanding > 0)) begin
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_data <= command_queue[0].word;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: idle_left = 0;
                  9:          idle_left = $urandom_range(10, 30);
                  default:    idle_left = $urandom_range(1, 5);
               endcase
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Monitor: every valid cycle carries one word; the oldest expectation must match it.
   always @(posedge clock) begin : check
      due_reply d;
      if (!reset && rsp_valid) begin
         // An expectation stamped in this very cycle cannot have its word out yet.
         if (replies_due.size() == 0 || replies_due[0].stamp == cycle_count) begin
            failed = 1'b1;
            $display("%0t: unexpected word status %0d granted_id %0d freed_count %0d",
                     $time, rsp_data.status, rsp_data.granted_id, rsp_data.freed_count);
         end else begin
            d = replies_due.pop_front();
            n_returned <= n_returned + 1;
            if (rsp_data.status !== d.word.status) begin
               failed = 1'b1;
               $display("%0t: status expected %0d actual %0d",
                        $time, d.word.status, rsp_data.status);
            end
            if (rsp_data.granted_id !== d.word.granted_id) begin
               failed = 1'b1;
               $display("%0t: granted_id expected %0d actual %0d",
                        $time, d.word.granted_id, rsp_data.granted_id);
            end
            if (rsp_data.freed_count !== d.word.freed_count) begin
               failed = 1'b1;
               $display("%0t: freed_count expected %0d actual %0d",
                        $time, d.word.freed_count, rsp_data.freed_count);
            end
         end
      end
   end

   initial begin
      int kind;
      int len;
      int own;
      bit hold;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      reset_pool();

      // Directed: full pool edges, ids 0 and 63, extreme owners, unused code.
      push_command(OP_UNUSED,   0,     0,  1'b0);
      push_command(OP_FREE,     0,     0,  1'b0);
      push_command(OP_FREE,     255,   63, 1'b0);
      push_command(OP_FREE_ALL, 0,     0,  1'b0);
      push_command(OP_ALLOC,    255,   63, 1'b0);
      push_command(OP_ALLOC,    0,     0,  1'b0);
      push_command(OP_ALLOC,    8'h55, 21, 1'b0);
      push_command(OP_ALLOC,    8'hAA, 42, 1'b0);
      push_command(OP_ALLOC,    0,     0,  1'b0);
      push_command(OP_FREE,     0,     1,  1'b0);
      push_command(OP_FREE,     0,     1,  1'b0);
      push_command(OP_FREE_ALL, 0,     63, 1'b0);
      push_command(OP_FREE_ALL, 0,     0,  1'b0);
      push_command(OP_FREE,     255,   0,  1'b0);
      push_command(OP_FREE_ALL, 255,   0,  1'b0);
      push_command(OP_FREE_ALL, 8'h55, 0,  1'b0);
      push_command(OP_UNUSED,   255,   63, 1'b0);
      push_command(OP_ALLOC,    0,     0,  1'b0);
      push_command(OP_FREE,     0,     6,  1'b0);
      push_command(OP_FREE,     0,     4,  1'b0);
      push_command(OP_FREE_ALL, 8'hAA, 0,  1'b0);

      while (real_items < TARGET_ITEMS) begin
         kind = $urandom_range(0, 99);
         hold = (n_queued == 0 && real_items < 25) || ($urandom_range(0, 19) == 0);
         if (kind < 34) begin
            len = $urandom_range(1, 12);
            own = pick_owner();
            for (int k = 0; k < len; k++)
               push_command(OP_ALLOC, ($urandom_range(0, 3) == 0) ? pick_owner() : own,
                            $urandom_range(0, 63), hold && k == 0);
         end else if (kind < 64) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
               push_command(OP_FREE, $urandom_range(0, 255),
                            ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 63),
                            hold && k == 0);
         end else if (kind < 76) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
               push_command(2'($urandom_range(0, 2)), pick_owner(), $urandom_range(0, 63),
                            hold && k == 0);
         end else if (kind < 88) begin
            push_command(OP_FREE_ALL, pick_owner(), $urandom_range(0, 63), hold);
         end else if (kind < 94) begin
            if ($urandom_range(0, 1) == 0)
               push_command(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 63), hold);
            else
               push_command(OP_FREE, $urandom_range(0, 255), 0, hold);
         end else if (kind < 95) begin
            // Drain the pool past empty, then hand back by owner everything that owners 0 to 3 hold.
            len = $urandom_range(66, 72);
            for (int k = 0; k < len; k++)
               push_command(OP_ALLOC, $urandom_range(0, 3), $urandom_range(0, 63),
                            hold && k == 0);
            for (int o = 0; o < 4; o++)
               push_command(OP_FREE_ALL, o, $urandom_range(0, 63), 1'b0);
         end else begin
            len = $urandom_range(1, 8);
            own = pick_owner();
            for (int k = 0; k < len; k++)
               push_command(OP_ALLOC, own, $urandom_range(0, 63), hold && k == 0);
            push_command(OP_FREE_ALL, own, $urandom_range(0, 63), 1'b0);
         end
         n_queued = command_queue.size();
      end
      n_queued = command_queue.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (!(n_accepted == n_queued && n_returned == n_accepted))
         @(posedge clock);
      // Allow a stray word time to show up.
      repeat (100) @(posedge clock);

      if (!failed && replies_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/bia_pkg.sv
rtl/core/bia_ctrl.sv
rtl/core/bia_datapath.sv
rtl/core/buffer_id_allocator_core.sv
rtl/core/bia_checker.sv
verif/buffer_id_allocator_core_tb.sv
